@@ rtl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  // Operation codes carried in the input transaction.
  localparam logic [2:0] OP_INS_SORT  = 3'd0;
  localparam logic [2:0] OP_INS_FRONT = 3'd1;
  localparam logic [2:0] OP_INS_BACK  = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  priority_req;
    logic [15:0] tag;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  count;
    logic        empty_res;
    logic [7:0]  head_priority;
    logic [15:0] head_tag;
    logic [7:0]  tail_priority;
    logic [15:0] tail_tag;
  } spq_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic apply;
    logic result;
  } spq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic no_change;
  } spq_sts_t;

endpackage

@@ rtl/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: controller plus entry datapath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in_     | input     | in_valid / in_stall  | spq_in_t  opcode, priority, tag
//   out_    | output    | out_valid / out_stall| spq_out_t status, count, head, tail
//
// Each transaction steps through accept, evaluate, update and result; one that
// changes nothing (rejected or unused opcode) skips the update step.
// The entries live in a row of DEPTH cells that shift as one; the insert
// point comes from per-cell compares registered in the evaluate cycle.
// Reset clears the fill count and handshake state; cell contents are not reset.
// The result register holds while out_valid and out_stall are high; a
// finished transaction waits in the result step until the register frees,
// and in_stall stays high from acceptance until the result is loaded.
`timescale 1ns / 1ps
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_out_t out_data
);

  spq_cmd_t cmd;
  spq_sts_t sts;

  // Sequence each transaction through evaluate, update and result.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the entries, decode the operation, shift the cells, build the result.
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ rtl/spq_ctrl.sv @@
// Sequencing state machine for the sorted priority queue.
`timescale 1ns / 1ps
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_cmd_t cmd,
  input  spq_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_APPLY  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.no_change ? S_RESULT : S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.result    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_rise_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result valid rose outside the result step");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && in_valid |=> (state_r == S_EVAL))
    else $error("accepted transaction did not enter evaluation");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) && out_valid_r && out_stall |=> (state_r == S_RESULT))
    else $error("result step left while output register was held");

endmodule

@@ rtl/spq_datapath.sv @@
// Entry cell row, operation decode and result register of the sorted priority queue.
`timescale 1ns / 1ps
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  spq_in_t  in_data,
  input  spq_cmd_t cmd,
  output spq_sts_t sts,
  output spq_out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    K_NONE,
    K_INS_FRONT,
    K_INS_BACK,
    K_INS_SORT,
    K_DEL_FRONT,
    K_DEL_BACK
  } kind_t;

  logic [7:0]  prio_r [DEPTH];
  logic [15:0] tag_r  [DEPTH];
  logic [CW-1:0] cnt_r;
  spq_in_t     req_r;
  kind_t       kind_r, kind_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [DEPTH-1:0] lt_r;
  logic        tail_ge_r;
  spq_out_t    out_r;

  logic          full, empty;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] tail_idx;
  logic [DEPTH-1:0] ge_cnt, sort_mask, ins_mask;
  logic          is_ins;
  logic [31:0]   cnt_ext;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign cnt_m1   = cnt_r - CW'(1);
  assign tail_idx = cnt_m1[IW-1:0];
  assign cnt_ext  = 32'(cnt_r);

  // Decode the operation against the current fill level.
  always_comb begin
    kind_nxt   = K_NONE;
    status_nxt = STAT_DONE;
    case (req_r.opcode)
      OP_INS_SORT, OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else if (req_r.opcode == OP_INS_FRONT) begin
          kind_nxt = K_INS_FRONT;
        end else if (req_r.opcode == OP_INS_BACK) begin
          kind_nxt = K_INS_BACK;
        end else begin
          kind_nxt = K_INS_SORT;
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else if (req_r.opcode == OP_DEL_FRONT) begin
          kind_nxt = K_DEL_FRONT;
        end else begin
          kind_nxt = K_DEL_BACK;
        end
      end
      default: begin
        kind_nxt = K_NONE;
      end
    endcase
  end

  assign sts.no_change = (kind_nxt == K_NONE);

  // Insertion mask: cells after the insert point take their left neighbor.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge_cnt[i] = (i >= int'(cnt_r));
    end
  end

  // Bits from the first lower-priority cell upward.
  assign sort_mask = lt_r | (~lt_r + {{(DEPTH-1){1'b0}}, 1'b1});

  always_comb begin
    ins_mask = '0;
    is_ins   = 1'b1;
    case (kind_r)
      K_INS_FRONT: ins_mask = '1;
      K_INS_BACK:  ins_mask = ge_cnt;
      K_INS_SORT:  ins_mask = tail_ge_r ? ge_cnt : sort_mask;
      default:     is_ins   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.eval) begin
      kind_r    <= kind_nxt;
      status_r  <= status_nxt;
      tail_ge_r <= empty || (prio_r[tail_idx] >= req_r.priority_req);
      for (int i = 0; i < DEPTH; i++) begin
        lt_r[i] <= (i < int'(cnt_r)) && (prio_r[i] < req_r.priority_req);
      end
    end
    if (cmd.result) begin
      out_r.status    <= status_r;
      out_r.count     <= cnt_ext[4:0];
      out_r.empty_res <= empty;
      out_r.head_priority <= empty ? 8'd0  : prio_r[0];
      out_r.head_tag      <= empty ? 16'd0 : tag_r[0];
      out_r.tail_priority <= empty ? 8'd0  : prio_r[tail_idx];
      out_r.tail_tag      <= empty ? 16'd0 : tag_r[tail_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.apply) begin
      if (is_ins) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (kind_r == K_DEL_FRONT || kind_r == K_DEL_BACK) begin
        cnt_r <= cnt_m1;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [7:0]  take_p, right_p;
    logic [15:0] take_t, right_t;

    if (g == 0) begin : g_first
      assign take_p = req_r.priority_req;
      assign take_t = req_r.tag;
    end else begin : g_rest
      assign take_p = ins_mask[g-1] ? prio_r[g-1] : req_r.priority_req;
      assign take_t = ins_mask[g-1] ? tag_r[g-1]  : req_r.tag;
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_p = prio_r[g];
      assign right_t = tag_r[g];
    end else begin : g_inner
      assign right_p = prio_r[g+1];
      assign right_t = tag_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        if (is_ins && ins_mask[g]) begin
          prio_r[g] <= take_p;
          tag_r[g]  <= take_t;
        end else if (kind_r == K_DEL_FRONT) begin
          prio_r[g] <= right_p;
          tag_r[g]  <= right_t;
        end
      end
    end
  end

  assign out_data = out_r;

  a_del_front_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && (kind_r == K_DEL_FRONT) |=> cnt_r == CW'($past(cnt_r) - CW'(1)))
    else $error("front removal did not drop the count by one");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result && (status_r == STAT_FULL) |-> cnt_r == CW'(DEPTH))
    else $error("full rejection reported below capacity");

  a_no_apply_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> kind_r != K_NONE)
    else $error("update step issued for an operation that changes nothing");

endmodule
